// ===== hdl/tha_pkg.sv =====
`default_nettype none

package tha_pkg;

    localparam int ADDR_W              = 32;
    localparam int PB_W                = 5;
    localparam int PCOUNT_W            = 8;
    localparam int NUM_PREFIX          = 9;
    localparam int COUNT_WIDTH_DEFAULT = 8;

    localparam logic [PB_W-1:0] PRIVACY_BITS_RESET = PB_W'(8);

    // Non-public prefixes: network and mask, checked in parallel
    localparam logic [ADDR_W-1:0] NP_NET [NUM_PREFIX] = '{
        32'h0000_0000, 32'h0A00_0000, 32'h7F00_0000, 32'hA9FE_0000, 32'hAC10_0000,
        32'hC000_0200, 32'hC058_6300, 32'hC0A8_0000, 32'hE000_0000
    };
    localparam logic [ADDR_W-1:0] NP_MASK [NUM_PREFIX] = '{
        32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 32'hFFFF_0000, 32'hFFF0_0000,
        32'hFFFF_FF00, 32'hFFFF_FF00, 32'hFFFF_0000, 32'hE000_0000
    };

    typedef struct packed {
        logic [ADDR_W-1:0] hop_address;
        logic              end_of_trace;
    } hop_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   out_address;
        logic                leading_private;
        logic [PCOUNT_W-1:0] private_count;
        logic                trace_done;
    } result_t;

    typedef struct packed {
        logic seen_public;
        logic count_zero;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/tha_np_check.sv =====
`default_nettype none

module tha_np_check (
    input  wire logic [tha_pkg::ADDR_W-1:0] addr,
    output logic                            non_public
);
    import tha_pkg::*;

    logic [NUM_PREFIX-1:0] hit;

    // Compare against every non-public prefix at once
    always_comb
    begin
        for (int k = 0; k < NUM_PREFIX; k++)
        begin
            hit[k] = ((addr & NP_MASK[k]) == NP_NET[k]);
        end
    end

    assign non_public = |hit;

endmodule

`default_nettype wire

// ===== hdl/tha_trace_state.sv =====
`default_nettype none

module tha_trace_state #(
    parameter int COUNT_WIDTH = tha_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire tha_pkg::hop_t                 hop,
    input  wire logic                          non_public,
    input  wire logic [tha_pkg::PB_W-1:0]      privacy_bits,
    output tha_pkg::result_t                   result,
    output tha_pkg::status_t                   status
);
    import tha_pkg::*;

    localparam int ExtW = COUNT_WIDTH + PCOUNT_W;

    logic                   seen_reg,  seen_next;
    logic [ADDR_W-1:0]      pub_reg,   pub_next;
    logic [COUNT_WIDTH-1:0] cnt_reg,   cnt_next;

    logic                   seen_upd;
    logic [ADDR_W-1:0]      pub_upd;
    logic [COUNT_WIDTH-1:0] cnt_upd;
    logic                   lead;
    logic [ADDR_W-1:0]      keep;
    logic                   in_subnet;
    logic [ExtW-1:0]        cnt_ext;

    // Classify the hop and work out the updated trace state
    always_comb
    begin
        seen_upd = seen_reg;
        pub_upd  = pub_reg;
        cnt_upd  = cnt_reg;
        lead     = 1'b0;
        if (!seen_reg)
        begin
            if (non_public)
            begin
                lead = 1'b1;
                if (cnt_reg != {COUNT_WIDTH{1'b1}})
                begin
                    cnt_upd = cnt_reg + COUNT_WIDTH'(1);
                end
            end
            else
            begin
                seen_upd = 1'b1;
                pub_upd  = hop.hop_address;
            end
        end

        keep      = {ADDR_W{1'b1}} << privacy_bits;
        in_subnet = seen_upd && (((hop.hop_address ^ pub_upd) & keep) == '0);
        cnt_ext   = ExtW'(cnt_upd);

        result.out_address     = in_subnet ? (hop.hop_address & keep) : hop.hop_address;
        result.leading_private = lead;
        result.private_count   = cnt_ext[PCOUNT_W-1:0];
        result.trace_done      = hop.end_of_trace;

        // Clear everything after the last hop of a trace
        if (hop.end_of_trace)
        begin
            seen_next = 1'b0;
            pub_next  = '0;
            cnt_next  = '0;
        end
        else
        begin
            seen_next = seen_upd;
            pub_next  = pub_upd;
            cnt_next  = cnt_upd;
        end
    end

    // Commit state as the item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            pub_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (advance)
        begin
            seen_reg <= seen_next;
            pub_reg  <= pub_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign status.seen_public = seen_reg;
    assign status.count_zero  = (cnt_reg == '0);

endmodule

`default_nettype wire

// ===== hdl/tha_out_reg.sv =====
`default_nettype none

module tha_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic             take,
    input  wire tha_pkg::result_t result_in,
    output logic                  valid,
    output tha_pkg::result_t      result_out
);
    import tha_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // Fill when loaded, empty when taken
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until a new item arrives
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign valid      = valid_reg;
    assign result_out = data_reg;

endmodule

`default_nettype wire

// ===== hdl/traceroute_hop_anonymizer_unit.sv =====
// Traceroute hop anonymizer.
// Input channel: hop_valid / hop_stall with hop_address and end_of_trace,
// one hop per item, hops of a trace in order, the last one flagged.
// Result channel: result_valid / result_stall with out_address,
// leading_private, private_count and trace_done, one result per hop.
// Configuration: cfg_valid / cfg_ready writes privacy_bits from cfg_data;
// cfg_ready is always high. Write it only while no hop is in flight.
// Path: an accepted hop is held in the input register, then moves to the
// result register once that is empty or being taken, and is presented
// from there while result_valid is high.
// Throughput: one hop per cycle while result_stall is low; the combinational
// classify-and-mask logic between the two registers includes the trace state update.
// Reset clears the trace state, empties both pipeline registers and sets
// privacy_bits to 8. When result_stall is high the result holds, the input
// register fills, and hop_stall then rises until the result is taken.
`default_nettype none

module traceroute_hop_anonymizer_unit #(
    parameter int COUNT_WIDTH = tha_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         hop_valid,
    output logic                              hop_stall,
    input  wire logic [tha_pkg::ADDR_W-1:0]   hop_address,
    input  wire logic                         end_of_trace,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic [tha_pkg::ADDR_W-1:0]        out_address,
    output logic                              leading_private,
    output logic [tha_pkg::PCOUNT_W-1:0]      private_count,
    output logic                              trace_done,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [tha_pkg::PB_W-1:0]     cfg_data
);
    import tha_pkg::*;

    logic            in_valid_reg, in_valid_next;
    hop_t            in_reg;
    logic [PB_W-1:0] pbits_reg;
    logic            advance;
    logic            hop_accept;
    logic            non_public;
    result_t         result_c;
    result_t         result_q;
    status_t         status;

    // Move on when the result register is empty or being taken
    assign advance    = !result_valid || !result_stall;
    assign hop_stall  = in_valid_reg && !advance;
    assign hop_accept = hop_valid && !hop_stall;
    assign cfg_ready  = 1'b1;

    // Input register control
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (hop_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the hop
    always_ff @(posedge clk)
    begin
        if (hop_accept)
        begin
            in_reg.hop_address  <= hop_address;
            in_reg.end_of_trace <= end_of_trace;
        end
    end

    // Privacy width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pbits_reg <= PRIVACY_BITS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pbits_reg <= cfg_data;
        end
    end

    tha_np_check u_np_check (
        .addr       (in_reg.hop_address),
        .non_public (non_public)
    );

    tha_trace_state #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_trace_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance && in_valid_reg),
        .hop          (in_reg),
        .non_public   (non_public),
        .privacy_bits (pbits_reg),
        .result       (result_c),
        .status       (status)
    );

    tha_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && in_valid_reg),
        .take       (!result_stall),
        .result_in  (result_c),
        .valid      (result_valid),
        .result_out (result_q)
    );

    assign out_address     = result_q.out_address;
    assign leading_private = result_q.leading_private;
    assign private_count   = result_q.private_count;
    assign trace_done      = result_q.trace_done;

    // Stall only with an item waiting in the input register
    a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        hop_stall |-> in_valid_reg)
        else $error("hop_stall without a held item");

    // A waiting item refills the result register as soon as it drains
    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> result_valid)
        else $error("result register not refilled");

    // Trace state is cleared once the last hop moves on
    a_trace_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance && in_reg.end_of_trace) |=>
            (!status.seen_public && status.count_zero))
        else $error("trace state not cleared after last hop");

    // No leading private hop is flagged after a public hop was seen
    a_no_lead_after_public: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && status.seen_public) |-> !result_c.leading_private)
        else $error("leading private flag after public hop");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
    import tha_pkg::*;

    localparam int COUNT_W      = COUNT_WIDTH_DEFAULT;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 100;

    // Directed hops: a hop in every non-public prefix, some at its edges, then a public hop
    // with hops inside and outside its subnet, then near misses of prefixes.
    localparam logic [ADDR_W-1:0] DIRECTED [20] = '{
        32'h0000_0000, 32'h0AFF_FFFF, 32'h7F00_0001, 32'hA9FE_0101, 32'hAC10_0000,
        32'hAC1F_FFFF, 32'hC000_0205, 32'hC058_6301, 32'hC0A8_0001, 32'hE000_0000,
        32'hFFFF_FFFF, 32'h0808_0808, 32'h0808_08C8, 32'h0808_0901, 32'h0A01_0101,
        32'h0808_08FF, 32'h0B00_0000, 32'hC000_0300, 32'hDFFF_FFFF, 32'h0A00_0001
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                hop_valid = 1'b0;
    logic                hop_stall;
    logic [ADDR_W-1:0]   hop_address = '0;
    logic                end_of_trace = 1'b0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [ADDR_W-1:0]   out_address;
    logic                leading_private;
    logic [PCOUNT_W-1:0] private_count;
    logic                trace_done;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [PB_W-1:0]     cfg_data = '0;

    // Predictor state: trace tracking and the register copy
    logic [PB_W-1:0]     privacy_bits_q;
    logic                trace_seen_public;
    logic [ADDR_W-1:0]   trace_first_public;
    logic [COUNT_W-1:0]  trace_lead_count;

    hop_t    hop_backlog[$];
    result_t predicted_hops[$];
    int      mismatches = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    traceroute_hop_anonymizer_unit #(
        .COUNT_WIDTH(COUNT_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .hop_valid(hop_valid),
        .hop_stall(hop_stall),
        .hop_address(hop_address),
        .end_of_trace(end_of_trace),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .out_address(out_address),
        .leading_private(leading_private),
        .private_count(private_count),
        .trace_done(trace_done),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic bit is_bogon(logic [ADDR_W-1:0] a);
        return a[31:24] == 8'd0 || a[31:24] == 8'd10 || a[31:24] == 8'd127 ||
               a[31:16] == 16'hA9FE || a[31:20] == 12'hAC1 ||
               a[31:8] == 24'hC0_0002 || a[31:8] == 24'hC0_5863 ||
               a[31:16] == 16'hC0A8 || a[31:29] == 3'b111;
    endfunction

    // Classify one hop, mask it against the first public subnet, advance the trace
    function automatic result_t anonymize_hop(hop_t h);
        logic [ADDR_W-1:0] keep;
        result_t r;
        keep = {ADDR_W{1'b1}} << privacy_bits_q;
        r.out_address = h.hop_address;
        r.leading_private = 1'b0;
        if (!trace_seen_public)
        begin
            if (is_bogon(h.hop_address))
            begin
                r.leading_private = 1'b1;
                if (trace_lead_count != {COUNT_W{1'b1}})
                    trace_lead_count = trace_lead_count + 1'b1;
            end
            else
            begin
                trace_seen_public = 1'b1;
                trace_first_public = h.hop_address;
            end
        end
        if (trace_seen_public && ((h.hop_address ^ trace_first_public) & keep) == '0)
            r.out_address = h.hop_address & keep;
        r.private_count = PCOUNT_W'(trace_lead_count);
        r.trace_done = h.end_of_trace;
        if (h.end_of_trace)
        begin
            trace_seen_public = 1'b0;
            trace_first_public = '0;
            trace_lead_count = '0;
        end
        return r;
    endfunction

    function automatic void push_hop(logic [ADDR_W-1:0] a, logic last);
        hop_t h;
        h.hop_address = a;
        h.end_of_trace = last;
        hop_backlog.push_back(h);
    endfunction

    function automatic logic [ADDR_W-1:0] bogon_addr();
        logic [ADDR_W-1:0] r;
        r = $urandom();
        case ($urandom_range(0, 8))
            0: return {8'd0, r[23:0]};
            1: return {8'd10, r[23:0]};
            2: return {8'd127, r[23:0]};
            3: return {16'hA9FE, r[15:0]};
            4: return {12'hAC1, r[19:0]};
            5: return {24'hC0_0002, r[7:0]};
            6: return {24'hC0_5863, r[7:0]};
            7: return {16'hC0A8, r[15:0]};
            default: return {3'b111, r[28:0]};
        endcase
    endfunction

    // Public address, often just outside one of the non-public prefixes
    function automatic logic [ADDR_W-1:0] public_addr();
        logic [ADDR_W-1:0] r;
        r = $urandom();
        if ($urandom_range(0, 2) == 0)
        begin
            case ($urandom_range(0, 7))
                0: r = {12'hAC2, r[19:0]};
                1: r = {8'd11, r[23:0]};
                2: r = {24'hC0_0003, r[7:0]};
                3: r = {16'hA9FF, r[15:0]};
                4: r = {16'hC0A9, r[15:0]};
                5: r = {8'd9, r[23:0]};
                6: r = {3'b110, r[28:0]};
                default: r = {24'hC0_5862, r[7:0]};
            endcase
        end
        while (is_bogon(r))
            r = $urandom();
        return r;
    endfunction

    // Queue one trace: leading bogons, then, when n_tail > 0, a first public hop and a mix of hops
    function automatic int queue_trace(int n_lead, int n_tail, bit close, logic [PB_W-1:0] pb);
        int total;
        int k;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] keep;
        logic [ADDR_W-1:0] a;
        total = n_lead + n_tail;
        keep = {ADDR_W{1'b1}} << pb;
        first = public_addr();
        for (k = 0; k < total; k++)
        begin
            if (k < n_lead)
                a = bogon_addr();
            else if (k == n_lead)
                a = first;
            else
            begin
                case ($urandom_range(0, 5))
                    0, 1: a = (first & keep) | (ADDR_W'($urandom()) & ~keep);
                    2: a = first;
                    3: a = public_addr();
                    4: a = bogon_addr();
                    default: a = $urandom();
                endcase
            end
            push_hop(a, close && k == total - 1);
        end
        return total;
    endfunction

    function automatic int queue_noise(int n);
        int k;
        for (k = 0; k < n; k++)
            push_hop($urandom(), $urandom_range(0, 3) == 0);
        return n;
    endfunction

    function automatic void fill_phase(int target, logic [PB_W-1:0] pb);
        int n;
        int pick;
        n = 0;
        while (n < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                n += queue_trace($urandom_range(0, 4), $urandom_range(1, 8), 1'b1, pb);
            else if (pick == 7)
                n += queue_noise($urandom_range(1, 6));
            else
                n += queue_trace($urandom_range(1, 5), $urandom_range(0, 2),
                                 $urandom_range(0, 1), pb);
        end
    endfunction

    // Driver: hold the item until accepted, then load the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        hop_t cur;
        hop_t nxt;
        if (!rst_n)
        begin
            hop_valid <= 1'b0;
            hop_address <= '0;
            end_of_trace <= 1'b0;
        end
        else
        begin
            if (hop_valid && !hop_stall)
            begin
                cur.hop_address = hop_address;
                cur.end_of_trace = end_of_trace;
                predicted_hops.push_back(anonymize_hop(cur));
            end
            if (!hop_valid || !hop_stall)
            begin
                if (hop_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = hop_backlog.pop_front();
                    hop_valid <= 1'b1;
                    hop_address <= nxt.hop_address;
                    end_of_trace <= nxt.end_of_trace;
                end
                else
                    hop_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (predicted_hops.size() == 0)
                begin
                    $error("unexpected result item, out_address %h", out_address);
                    mismatches++;
                end
                else
                begin
                    want = predicted_hops.pop_front();
                    if (out_address !== want.out_address)
                    begin
                        $error("out_address: expected %h, got %h", want.out_address, out_address);
                        mismatches++;
                    end
                    if (leading_private !== want.leading_private)
                    begin
                        $error("leading_private: expected %b, got %b",
                               want.leading_private, leading_private);
                        mismatches++;
                    end
                    if (private_count !== want.private_count)
                    begin
                        $error("private_count: expected %0d, got %0d",
                               want.private_count, private_count);
                        mismatches++;
                    end
                    if (trace_done !== want.trace_done)
                    begin
                        $error("trace_done: expected %b, got %b", want.trace_done, trace_done);
                        mismatches++;
                    end
                end
            end
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Hold the sender off until every predicted result has come out
    task automatic wait_drain();
        while (hop_backlog.size() != 0 || hop_valid || predicted_hops.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_privacy(logic [PB_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        privacy_bits_q = v;
    endtask

    initial
    begin
        int i;
        int phase;
        logic [PB_W-1:0] pb;
        privacy_bits_q = PRIVACY_BITS_RESET;
        trace_seen_public = 1'b0;
        trace_first_public = '0;
        trace_lead_count = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed hops under the reset register value
        send_idle_pct = 31;
        recv_idle_pct = 46;
        for (i = 0; i < 20; i++)
            push_hop(DIRECTED[i], i == 15 || i == 18 || i == 19);
        wait_drain();

        // Random phases, one register setting each
        for (phase = 0; phase < PHASES; phase++)
        begin
            send_idle_pct = (phase < 2) ? 31 : (phase < 4) ? 46 : 0;
            recv_idle_pct = (phase < 2) ? 46 : (phase < 4) ? 31 : 0;
            case (phase)
                0: pb = PB_W'(31);
                1: pb = PB_W'(0);
                2: pb = PB_W'(16);
                3: pb = PB_W'($urandom_range(1, 30));
                4: pb = PB_W'(1);
                default: pb = PB_W'(24);
            endcase
            write_privacy(pb);
            // Long run of bogons drives the lead count into saturation
            if (phase == 2)
                void'(queue_trace(270, 3, 1'b1, pb));
            fill_phase(PHASE_ITEMS, pb);
            // Leave a trace open so the next setting lands mid-trace
            if (phase == 1 || phase == 3)
                void'(queue_trace(2, 2, 1'b0, pb));
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== traceroute_hop_anonymizer_unit.f =====
hdl/tha_pkg.sv
hdl/tha_np_check.sv
hdl/tha_trace_state.sv
hdl/tha_out_reg.sv
hdl/traceroute_hop_anonymizer_unit.sv
tb/tb.sv
